// ===== rtl/assert_macros.svh =====
// assertion macros, included by rtl/nearest_to_centroid_select.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising clock edge, reset held low included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

// checked only while out of reset
`define ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`endif

// ===== rtl/ncs_pkg.sv =====
// constants, types and codes for the nearest-to-centroid select block
`default_nettype none

package ncs_pkg;

  localparam int MAX_REF    = 16;
  localparam int MAX_CAND   = 64;
  localparam int COORD_BITS = 16;

  localparam int REF_CNT_W  = $clog2(MAX_REF + 1);
  localparam int CNT_W      = $clog2(MAX_CAND + 1);
  localparam int IDX_W      = $clog2(MAX_CAND);
  localparam int SUM_W      = COORD_BITS + $clog2(MAX_REF);
  localparam int PROD_W     = COORD_BITS + REF_CNT_W + 1;
  localparam int ABS_W      = PROD_W - 1;
  localparam int SQ_W       = 2 * ABS_W;
  localparam int DIST_W     = SQ_W + 1;
  localparam int OUT_IDX_W  = 6;

  typedef enum logic [1:0] {
    KIND_REF    = 2'd0,
    KIND_CAND   = 2'd1,
    KIND_SELECT = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_START = 8'b0000_0010,
    S_READ  = 8'b0000_0100,
    S_DX    = 8'b0000_1000,
    S_SQX   = 8'b0001_0000,
    S_SQY   = 8'b0010_0000,
    S_CMP   = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/nearest_to_centroid_select.sv =====
// top level: picks the stored candidates nearest the reference centroid
//
// kind 0 beats add a reference point (up to 16), kind 1 beats store a candidate point
// (up to 64), kind 2 starts a select. a select makes one result beat per reference point:
// each is the untaken candidate with the smallest |n*c - sum|^2, ties to the lowest
// load index, or a none_left beat once candidates run out; the final beat has last set,
// then both point sets are cleared. the candidate scan sets how long a select runs:
// every untaken candidate goes through one memory read, two offset steps, one shared
// squaring multiplier twice and one add-and-compare. in_ready_o is low for the whole
// select. one output register holds a result beat, so a load may be accepted while the
// final result of a select still waits to be taken.
`default_nettype none

`include "assert_macros.svh"

module nearest_to_centroid_select (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [1:0]                           kind_i,
  input  wire logic signed [ncs_pkg::COORD_BITS-1:0] x_i,
  input  wire logic signed [ncs_pkg::COORD_BITS-1:0] y_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [ncs_pkg::OUT_IDX_W-1:0]             index_o,
  output logic signed [ncs_pkg::COORD_BITS-1:0]     pick_x_o,
  output logic signed [ncs_pkg::COORD_BITS-1:0]     pick_y_o,
  output logic                                      none_left_o,
  output logic                                      last_o
);

  localparam int CB = ncs_pkg::COORD_BITS;

  ncs_pkg::state_e state_q, state_d;

  // reference accumulators
  logic signed [ncs_pkg::SUM_W-1:0]  sum_x_q, sum_y_q;
  logic [ncs_pkg::REF_CNT_W-1:0]     ref_cnt_q;
  logic [ncs_pkg::CNT_W-1:0]         cand_cnt_q;
  logic [ncs_pkg::MAX_CAND-1:0]      taken_q;

  // candidate memory, {y, x} per entry
  logic [2*CB-1:0] cand_mem [ncs_pkg::MAX_CAND];
  logic [2*CB-1:0] rd_q;

  // scan state
  logic [ncs_pkg::IDX_W-1:0]     scan_q;
  logic [ncs_pkg::REF_CNT_W-1:0] pick_q;
  logic                          found_q;
  logic [ncs_pkg::IDX_W-1:0]     best_idx_q;
  logic [2*CB-1:0]               best_data_q;
  logic [ncs_pkg::DIST_W-1:0]    best_dist_q;

  // shared datapath registers
  logic [ncs_pkg::ABS_W-1:0] d_q;
  logic [ncs_pkg::SQ_W-1:0]  sqx_q, sqy_q;

  // output register
  logic                          out_valid_q;
  logic [ncs_pkg::OUT_IDX_W-1:0] index_q;
  logic [CB-1:0]                 pick_x_q, pick_y_q;
  logic                          none_left_q, last_q;

  logic in_fire, emit_go, scan_end, pick_last;
  logic ref_room, cand_room;
  logic signed [ncs_pkg::PROD_W-1:0] off_n, off_c, off_s, off_diff;
  logic [ncs_pkg::ABS_W-1:0]         off_abs;
  logic [ncs_pkg::SQ_W-1:0]          sq_res;
  logic [ncs_pkg::DIST_W-1:0]        dist_sum;
  logic                              better;

  assign in_ready_o = (state_q == ncs_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign emit_go    = (state_q == ncs_pkg::S_EMIT) && (!out_valid_q || out_ready_i);
  assign scan_end   = (ncs_pkg::CNT_W'(scan_q) + ncs_pkg::CNT_W'(1)) == cand_cnt_q;
  assign pick_last  = (pick_q + ncs_pkg::REF_CNT_W'(1)) == ref_cnt_q;
  assign ref_room   = ref_cnt_q < ncs_pkg::REF_CNT_W'(ncs_pkg::MAX_REF);
  assign cand_room  = cand_cnt_q < ncs_pkg::CNT_W'(ncs_pkg::MAX_CAND);

  // offset step: n*c - sum for x in S_DX, for y in S_SQX
  always_comb begin
    off_n = ncs_pkg::PROD_W'(ref_cnt_q);
    if (state_q == ncs_pkg::S_DX) begin
      off_c = ncs_pkg::PROD_W'($signed(rd_q[CB-1:0]));
      off_s = ncs_pkg::PROD_W'(sum_x_q);
    end else begin
      off_c = ncs_pkg::PROD_W'($signed(rd_q[2*CB-1:CB]));
      off_s = ncs_pkg::PROD_W'(sum_y_q);
    end
    off_diff = off_n * off_c - off_s;
    off_abs  = off_diff[ncs_pkg::PROD_W-1] ? ncs_pkg::ABS_W'(-off_diff)
                                           : ncs_pkg::ABS_W'(off_diff);
  end

  // the shared squaring unit
  assign sq_res   = d_q * d_q;
  assign dist_sum = ncs_pkg::DIST_W'(sqx_q) + ncs_pkg::DIST_W'(sqy_q);
  assign better   = !found_q || (dist_sum < best_dist_q);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ncs_pkg::S_IDLE: begin
        if (in_fire && kind_i == ncs_pkg::KIND_SELECT && ref_cnt_q != '0) begin
          state_d = ncs_pkg::S_START;
        end
      end
      ncs_pkg::S_START: begin
        state_d = (cand_cnt_q == '0) ? ncs_pkg::S_EMIT : ncs_pkg::S_READ;
      end
      ncs_pkg::S_READ: begin
        if (!taken_q[scan_q]) begin
          state_d = ncs_pkg::S_DX;
        end else if (scan_end) begin
          state_d = ncs_pkg::S_EMIT;
        end
      end
      ncs_pkg::S_DX:  state_d = ncs_pkg::S_SQX;
      ncs_pkg::S_SQX: state_d = ncs_pkg::S_SQY;
      ncs_pkg::S_SQY: state_d = ncs_pkg::S_CMP;
      ncs_pkg::S_CMP: state_d = scan_end ? ncs_pkg::S_EMIT : ncs_pkg::S_READ;
      ncs_pkg::S_EMIT: begin
        if (emit_go) begin
          state_d = pick_last ? ncs_pkg::S_IDLE : ncs_pkg::S_START;
        end
      end
      default: state_d = ncs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ncs_pkg::S_IDLE;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      ref_cnt_q   <= '0;
      cand_cnt_q  <= '0;
      taken_q     <= '0;
      scan_q      <= '0;
      pick_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // a taken beat leaves unless a new one replaces it
      if (out_valid_q && out_ready_i && !emit_go) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ncs_pkg::S_IDLE: begin
          pick_q <= '0;
          if (in_fire) begin
            unique case (kind_i)
              ncs_pkg::KIND_REF: begin
                if (ref_room) begin
                  sum_x_q   <= sum_x_q + ncs_pkg::SUM_W'(x_i);
                  sum_y_q   <= sum_y_q + ncs_pkg::SUM_W'(y_i);
                  ref_cnt_q <= ref_cnt_q + ncs_pkg::REF_CNT_W'(1);
                end
              end
              ncs_pkg::KIND_CAND: begin
                if (cand_room) begin
                  taken_q[cand_cnt_q[ncs_pkg::IDX_W-1:0]] <= 1'b0;
                  cand_cnt_q <= cand_cnt_q + ncs_pkg::CNT_W'(1);
                end
              end
              ncs_pkg::KIND_SELECT: begin
                // select with no references clears at once
                if (ref_cnt_q == '0) begin
                  sum_x_q    <= '0;
                  sum_y_q    <= '0;
                  cand_cnt_q <= '0;
                  taken_q    <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        ncs_pkg::S_START: begin
          scan_q  <= '0;
          found_q <= 1'b0;
        end
        ncs_pkg::S_READ: begin
          if (taken_q[scan_q] && !scan_end) begin
            scan_q <= scan_q + ncs_pkg::IDX_W'(1);
          end
        end
        ncs_pkg::S_CMP: begin
          if (better) begin
            found_q <= 1'b1;
          end
          if (!scan_end) begin
            scan_q <= scan_q + ncs_pkg::IDX_W'(1);
          end
        end
        ncs_pkg::S_EMIT: begin
          if (emit_go) begin
            out_valid_q <= 1'b1;
            pick_q      <= pick_q + ncs_pkg::REF_CNT_W'(1);
            if (pick_last) begin
              sum_x_q    <= '0;
              sum_y_q    <= '0;
              ref_cnt_q  <= '0;
              cand_cnt_q <= '0;
              taken_q    <= '0;
            end else if (found_q) begin
              taken_q[best_idx_q] <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire && kind_i == ncs_pkg::KIND_CAND && cand_room) begin
      cand_mem[cand_cnt_q[ncs_pkg::IDX_W-1:0]] <= {y_i, x_i};
    end
    rd_q <= cand_mem[scan_q];
    if (state_q == ncs_pkg::S_DX || state_q == ncs_pkg::S_SQX) begin
      d_q <= off_abs;
    end
    if (state_q == ncs_pkg::S_SQX) begin
      sqx_q <= sq_res;
    end
    if (state_q == ncs_pkg::S_SQY) begin
      sqy_q <= sq_res;
    end
    if (state_q == ncs_pkg::S_CMP && better) begin
      best_dist_q <= dist_sum;
      best_idx_q  <= scan_q;
      best_data_q <= rd_q;
    end
    if (emit_go) begin
      last_q      <= pick_last;
      none_left_q <= !found_q;
      if (found_q) begin
        index_q  <= ncs_pkg::OUT_IDX_W'(best_idx_q);
        pick_x_q <= best_data_q[CB-1:0];
        pick_y_q <= best_data_q[2*CB-1:CB];
      end else begin
        index_q  <= '0;
        pick_x_q <= '0;
        pick_y_q <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign index_o     = index_q;
  assign pick_x_o    = $signed(pick_x_q);
  assign pick_y_o    = $signed(pick_y_q);
  assign none_left_o = none_left_q;
  assign last_o      = last_q;

  `ASSERT_RUN(a_no_double_take,
    (emit_go && found_q) |-> !taken_q[best_idx_q], "picked a candidate already taken")
  `ASSERT_RUN(a_scan_in_range,
    (state_q == ncs_pkg::S_CMP) |-> (ncs_pkg::CNT_W'(scan_q) < cand_cnt_q),
    "scan index past stored candidates")
  `ASSERT_RUN(a_clear_after_last,
    (emit_go && pick_last) |=> (ref_cnt_q == '0 && cand_cnt_q == '0 && taken_q == '0),
    "point sets not cleared after final beat")
  `ASSERT_RUN(a_counts_bounded,
    (ref_cnt_q <= ncs_pkg::REF_CNT_W'(ncs_pkg::MAX_REF))
      && (cand_cnt_q <= ncs_pkg::CNT_W'(ncs_pkg::MAX_CAND)),
    "point count beyond capacity")

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// testbench for the nearest-to-centroid select block: directed and random point sets
`timescale 1ns / 100ps

module tb_top;

  localparam int CW        = ncs_pkg::COORD_BITS;
  localparam int LIMIT     = 1_000_000;
  // the tail after the last expected pick outlasts a select of 16 picks over 64
  // candidates, so it leaves room for anything still in flight
  localparam int TAIL      = 6000;
  localparam int N_ITEMS   = 170;

  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct {
    ncs_pkg::kind_e         kind;
    logic signed [CW-1:0]   x;
    logic signed [CW-1:0]   y;
  } beat_t;

  typedef struct {
    logic [ncs_pkg::OUT_IDX_W-1:0] index;
    logic signed [CW-1:0]          px;
    logic signed [CW-1:0]          py;
    logic                          none_left;
    logic                          last;
  } pick_t;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  logic [1:0]                    kind_i      = ncs_pkg::KIND_NONE;
  logic signed [CW-1:0]          x_i         = '0;
  logic signed [CW-1:0]          y_i         = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [ncs_pkg::OUT_IDX_W-1:0] index_o;
  logic signed [CW-1:0]          pick_x_o;
  logic signed [CW-1:0]          pick_y_o;
  logic                          none_left_o;
  logic                          last_o;

  nearest_to_centroid_select i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .x_i         (x_i),
    .y_i         (y_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .index_o     (index_o),
    .pick_x_o    (pick_x_o),
    .pick_y_o    (pick_y_o),
    .none_left_o (none_left_o),
    .last_o      (last_o)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // own copy of the point sets, updated on every accepted input beat
  // ---------------------------------------------------------------------------
  longint               sum_x;
  longint               sum_y;
  int unsigned          ref_n;
  logic signed [CW-1:0] cand_x [ncs_pkg::MAX_CAND];
  logic signed [CW-1:0] cand_y [ncs_pkg::MAX_CAND];
  int unsigned          cand_n;
  logic [ncs_pkg::MAX_CAND-1:0] taken;

  beat_t beats_pending[$];
  pick_t picks_due[$];

  int unsigned errors = 0;
  int unsigned cycles = 0;

  // squared distance of a candidate to the centroid, scaled by n on both axes
  function automatic longint scaled_dist(int unsigned n, logic signed [CW-1:0] cx,
                                         logic signed [CW-1:0] cy);
    longint dx;
    longint dy;
    dx = longint'(n) * longint'(cx) - sum_x;
    dy = longint'(n) * longint'(cy) - sum_y;
    return dx * dx + dy * dy;
  endfunction

  function automatic void step_point_sets(beat_t b);
    pick_t       p;
    longint      best_d;
    longint      d;
    int unsigned best;
    bit          found;
    unique case (b.kind)
      ncs_pkg::KIND_REF: begin
        // a full reference set drops further loads
        if (ref_n < ncs_pkg::MAX_REF) begin
          sum_x += longint'(b.x);
          sum_y += longint'(b.y);
          ref_n++;
        end
      end
      ncs_pkg::KIND_CAND: begin
        if (cand_n < ncs_pkg::MAX_CAND) begin
          cand_x[cand_n] = b.x;
          cand_y[cand_n] = b.y;
          taken[cand_n]  = 1'b0;
          cand_n++;
        end
      end
      ncs_pkg::KIND_SELECT: begin
        // one pick per reference point; strict compare keeps ties on the lowest index
        for (int unsigned k = 0; k < ref_n; k++) begin
          found  = 1'b0;
          best   = 0;
          best_d = 0;
          for (int unsigned i = 0; i < cand_n; i++) begin
            if (!taken[i]) begin
              d = scaled_dist(ref_n, cand_x[i], cand_y[i]);
              if (!found || d < best_d) begin
                found  = 1'b1;
                best   = i;
                best_d = d;
              end
            end
          end
          if (found) begin
            taken[best]  = 1'b1;
            p.index      = best[ncs_pkg::OUT_IDX_W-1:0];
            p.px         = cand_x[best];
            p.py         = cand_y[best];
            p.none_left  = 1'b0;
          end else begin
            // candidates ran out: zero fields with the flag
            p.index      = '0;
            p.px         = '0;
            p.py         = '0;
            p.none_left  = 1'b1;
          end
          p.last = (k + 1 == ref_n);
          picks_due.insert(picks_due.size(), p);
        end
        // a select clears both sets, even one with no references
        sum_x  = 0;
        sum_y  = 0;
        ref_n  = 0;
        cand_n = 0;
        taken  = '0;
      end
      default: ;  // unused kind leaves everything alone
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus planning
  // ---------------------------------------------------------------------------
  int unsigned planned_items = 0;

  function automatic void push_beat(ncs_pkg::kind_e k, logic signed [CW-1:0] x,
                                    logic signed [CW-1:0] y);
    beat_t b;
    b.kind = k;
    b.x    = x;
    b.y    = y;
    beats_pending.insert(beats_pending.size(), b);
    planned_items++;
  endfunction

  // mostly full-range values, some extremes, some clustered near zero for ties
  function automatic logic signed [CW-1:0] rand_coord();
    int unsigned r;
    logic [31:0] w;
    int          s;
    r = $urandom_range(0, 99);
    w = $urandom();
    if (r < 15) begin
      case (w[1:0])
        2'd0:    return C_MAX;
        2'd1:    return C_MIN;
        2'd2:    return '0;
        default: return '1;
      endcase
    end else if (r < 35) begin
      s = $urandom_range(0, 8);
      s = s - 4;
      return s[CW-1:0];
    end
    return w[CW-1:0];
  endfunction

  // reference and candidate loads in random order, with occasional unused-kind beats when noisy, then a select
  function automatic void plan_sequence(int unsigned nref, int unsigned ncand, bit noisy);
    int unsigned r_left;
    int unsigned c_left;
    r_left = nref;
    c_left = ncand;
    while (r_left + c_left > 0) begin
      if ($urandom_range(1, r_left + c_left) <= r_left) begin
        push_beat(ncs_pkg::KIND_REF, rand_coord(), rand_coord());
        r_left--;
      end else begin
        push_beat(ncs_pkg::KIND_CAND, rand_coord(), rand_coord());
        c_left--;
      end
      if (noisy && $urandom_range(0, 9) == 0)
        push_beat(ncs_pkg::KIND_NONE, rand_coord(), rand_coord());
    end
    push_beat(ncs_pkg::KIND_SELECT, rand_coord(), rand_coord());
  endfunction

  // ---------------------------------------------------------------------------
  // driver: bursts of random length with random gaps, fed from beats_pending
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin : drive_inputs
    beat_t b;
    logic  take;
    if (rst_ni) begin
      take = in_valid_i && in_ready_o;
      if (take) begin
        b.kind = ncs_pkg::kind_e'(kind_i);
        b.x    = x_i;
        b.y    = y_i;
        step_point_sets(b);
      end
      // valid only changes when idle or right after an accepted beat
      if (!in_valid_i || take) begin
        if (gap_left > 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (beats_pending.size() > 0) begin
          b = beats_pending.pop_front();
          in_valid_i <= 1'b1;
          kind_i     <= b.kind;
          x_i        <= b.x;
          y_i        <= b.y;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left   <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks every accepted result beat, receiver stalls by phase
  // ---------------------------------------------------------------------------
  int unsigned    stall_mode  = 0;
  int unsigned    stall_phase = 0;
  int unsigned    stall_step  = 0;
  logic [15:0]    stall_mask  = '1;

  function automatic void flag(string what);
    errors++;
    if (errors <= 10) $display("%s", what);
  endfunction

  always @(posedge clk_i) begin : watch_outputs
    pick_t e;
    logic  nxt;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (picks_due.size() == 0) begin
          flag($sformatf("unexpected pick: index %0d x %0d y %0d none_left %0b last %0b",
                         index_o, pick_x_o, pick_y_o, none_left_o, last_o));
        end else begin
          e = picks_due.pop_front();
          if (index_o !== e.index || pick_x_o !== e.px || pick_y_o !== e.py ||
              none_left_o !== e.none_left || last_o !== e.last)
            flag($sformatf({"pick mismatch: expected index %0d x %0d y %0d none_left %0b ",
                            "last %0b, got index %0d x %0d y %0d none_left %0b last %0b"},
                           e.index, e.px, e.py, e.none_left, e.last,
                           index_o, pick_x_o, pick_y_o, none_left_o, last_o));
        end
      end
      // each stall phase picks one mode: always ready, a rotating mask, or random stalls
      if (stall_phase == 199) begin
        stall_phase <= 0;
        stall_mode  <= $urandom_range(0, 2);
        stall_mask  <= 16'($urandom()) | 16'd1;
      end else begin
        stall_phase <= stall_phase + 1;
      end
      stall_step <= stall_step + 1;
      case (stall_mode)
        0:       nxt = 1'b1;
        1:       nxt = stall_mask[stall_step[3:0]];
        default: nxt = ($urandom_range(0, 2) != 0);
      endcase
      out_ready_i <= nxt;
    end
  end

  // hard stop well beyond the slowest correct run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    int unsigned seq;
    int unsigned r;
    sum_x  = 0;
    sum_y  = 0;
    ref_n  = 0;
    cand_n = 0;
    taken  = '0;

    // select on empty sets, then an unused kind with extreme coordinates
    push_beat(ncs_pkg::KIND_SELECT, C_MAX, C_MIN);
    push_beat(ncs_pkg::KIND_NONE, C_MIN, C_MAX);
    // extreme points, duplicate candidates, more picks than candidates
    push_beat(ncs_pkg::KIND_REF, C_MAX, C_MIN);
    push_beat(ncs_pkg::KIND_CAND, C_MIN, C_MAX);
    push_beat(ncs_pkg::KIND_CAND, C_MAX, C_MIN);
    push_beat(ncs_pkg::KIND_CAND, C_MAX, C_MIN);
    push_beat(ncs_pkg::KIND_NONE, '1, '0);
    push_beat(ncs_pkg::KIND_REF, C_MAX, C_MIN);
    push_beat(ncs_pkg::KIND_REF, C_MIN, C_MAX);
    push_beat(ncs_pkg::KIND_REF, '0, '0);
    push_beat(ncs_pkg::KIND_SELECT, '1, '1);
    // three candidates at equal distance: order must follow load index
    push_beat(ncs_pkg::KIND_REF, '0, '0);
    push_beat(ncs_pkg::KIND_CAND, CW'(16), '0);
    push_beat(ncs_pkg::KIND_CAND, CW'(-16), '0);
    push_beat(ncs_pkg::KIND_CAND, '0, CW'(16));
    push_beat(ncs_pkg::KIND_REF, '0, '0);
    push_beat(ncs_pkg::KIND_SELECT, C_MIN, C_MAX);
    // references with no candidates at all
    push_beat(ncs_pkg::KIND_REF, '1, '1);
    push_beat(ncs_pkg::KIND_SELECT, '0, '0);
    // candidates with no references: nothing comes out, sets still cleared
    push_beat(ncs_pkg::KIND_CAND, '1, '0);
    push_beat(ncs_pkg::KIND_SELECT, '0, '1);

    // random part: mostly well-formed sequences, a full reference set and a
    // full candidate set once each, some noise and lone selects
    seq = 0;
    while (planned_items < N_ITEMS) begin
      r = $urandom_range(0, 99);
      if (seq == 3)
        plan_sequence(ncs_pkg::MAX_REF + $urandom_range(1, 2), $urandom_range(0, 20), 1'b0);
      else if (seq == 7)
        plan_sequence($urandom_range(1, 4), ncs_pkg::MAX_CAND + $urandom_range(1, 2), 1'b0);
      else if (r < 6)
        push_beat(ncs_pkg::KIND_NONE, rand_coord(), rand_coord());
      else if (r < 10)
        push_beat(ncs_pkg::KIND_SELECT, rand_coord(), rand_coord());
      else
        plan_sequence($urandom_range(0, 6), $urandom_range(0, 10), r < 40);
      seq++;
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all beats accepted and all picks seen, then a quiet tail
    while (beats_pending.size() != 0 || in_valid_i || picks_due.size() != 0)
      @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);

    if (picks_due.size() != 0)
      flag($sformatf("%0d picks never arrived", picks_due.size()));

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
